// ===== src/isched_pkg.sv =====
// isched_pkg: shared widths, constants and control types for the interval scheduler
// no dependencies; imported by the interfaces, the controller, the datapath and the top level
package isched_pkg;

    localparam int START_W   = 11;
    localparam int DUR_W     = 12;
    localparam int END_W     = 13;
    localparam int COUNT_W   = 9;
    localparam int GAP_W     = 11;

    localparam logic [GAP_W-1:0]   GAP_RESET = 11'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // one stored interval
    typedef struct packed {
        logic [START_W-1:0] start_min;
        logic [END_W-1:0]   end_min;
    } isched_entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic place;
        logic shift;
        logic scan_rd;
        logic scan_start;
        logic scan_first;
        logic scan_step;
        logic load_result;
    } isched_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic greater;
        logic last_item;
        logic scan_last;
        logic out_free;
    } isched_status_t;

endpackage

// ===== src/isched_in_if.sv =====
// isched_in_if: input channel carrying one interval per beat
// depends on isched_pkg for field widths
interface isched_in_if
    import isched_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_minute;
    logic [DUR_W-1:0]   duration;
    logic               last_film;

    modport source (output valid, output start_minute, output duration, output last_film,
                    input ready);
    modport sink   (input valid, input start_minute, input duration, input last_film,
                    output ready);
endinterface

// ===== src/isched_out_if.sv =====
// isched_out_if: result channel carrying one count per beat
// depends on isched_pkg for field widths
interface isched_out_if
    import isched_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] max_count;

    modport source (output valid, output max_count, input ready);
    modport sink   (input valid, input max_count, output ready);
endinterface

// ===== src/interval_schedule_max_count_unit.sv =====
// interval_schedule_max_count_unit: top level of the greedy interval scheduler
// depends on isched_pkg, isched_in_if, isched_out_if, isched_ctrl and isched_dp

// Intervals arrive one beat at a time on in_ch (start minute, duration, last flag) and
// are kept in a single-port-read, single-port-write store of MAX_FILMS entries, sorted
// by start on the way in (stable for equal starts). An accepted beat is inserted before the
// next one is taken; the insertion shifts each stored interval with a later start up by one
// entry, one entry per cycle, through the store's one read and one write port. A beat
// into an empty store, or one dropped because the store is full, needs no shift. Beats
// arriving with the store full are dropped but their last flag still counts. The beat
// flagged last adds a greedy scan of the N stored intervals, one store read per cycle,
// plus any wait for the previous count to leave the output register; one count beat
// then appears on out_ch. That count waits in an output
// register, so the next set may start while it is still pending. gap_minutes
// (reset 10) is written through cfg_wr_en / cfg_wr_data and must only change while the
// unit is idle. No clearing pass is needed after reset: only entries of the current set
// are ever read.
module interval_schedule_max_count_unit
    import isched_pkg::*;
#(
    parameter int MAX_FILMS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [GAP_W-1:0] cfg_wr_data,
    isched_in_if.sink        in_ch,
    isched_out_if.source     out_ch
);

    // command and status bundles between sequencer and datapath
    isched_cmd_t    cmd;
    isched_status_t status;
    logic           in_ready;

    // sequencer: insertion steps, scan steps, result hand-off
    isched_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: sorted store, greedy registers, gap register, output register
    isched_dp #(
        .MAX_FILMS (MAX_FILMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_start    (in_ch.start_minute),
        .in_duration (in_ch.duration),
        .in_last     (in_ch.last_film),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_count   (out_ch.max_count)
    );

    // input beats are taken only while the sequencer is idle
    assign in_ch.ready = in_ready;

endmodule

// ===== src/isched_ctrl.sv =====
// isched_ctrl: sequencer for insertion, greedy scan and result hand-off
// depends on isched_pkg for the command and status types
module isched_ctrl
    import isched_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  isched_status_t status,
    output isched_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_SHIFT,
        ST_SCAN_INIT,
        ST_SCAN_FIRST,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                if (status.full)
                begin
                    state_next = status.last_item ? ST_SCAN_INIT : ST_IDLE;
                end
                else if (status.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = status.last_item ? ST_SCAN_INIT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (status.pos_zero || !status.greater)
                begin
                    cmd.place  = 1'b1;
                    state_next = status.last_item ? ST_SCAN_INIT : ST_IDLE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_rd    = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN_FIRST;
            end
            ST_SCAN_FIRST:
            begin
                cmd.scan_rd    = 1'b1;
                cmd.scan_first = 1'b1;
                state_next     = status.scan_last ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_rd   = 1'b1;
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // ready only while waiting for a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> (state_reg == ST_IDLE))
        else $error("isched_ctrl: ready raised outside idle");

    // at most one datapath action per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.place, cmd.shift, cmd.scan_first, cmd.scan_step,
                  cmd.load_result}))
        else $error("isched_ctrl: conflicting datapath commands");

    // the scan loop is entered only from its first step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            ($past(state_reg) == ST_SCAN_FIRST || $past(state_reg) == ST_SCAN))
        else $error("isched_ctrl: scan entered without first entry");
`endif

endmodule

// ===== src/isched_dp.sv =====
// isched_dp: interval store, insertion pointer, greedy scan registers and result register
// depends on isched_pkg for widths, entry layout and the command and status types
module isched_dp
    import isched_pkg::*;
#(
    parameter int MAX_FILMS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  isched_cmd_t        cmd,
    output isched_status_t     status,
    input  logic               cfg_wr_en,
    input  logic [GAP_W-1:0]   cfg_wr_data,
    input  logic [START_W-1:0] in_start,
    input  logic [DUR_W-1:0]   in_duration,
    input  logic               in_last,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [COUNT_W-1:0] out_count
);

    localparam int AW = $clog2(MAX_FILMS);
    localparam int CW = $clog2(MAX_FILMS + 1);
    localparam int SUM_W = END_W + 1;

    isched_entry_t mem [MAX_FILMS];
    isched_entry_t rd_data_reg;

    logic [START_W-1:0] item_start_reg;
    logic [END_W-1:0]   item_end_reg;
    logic               item_last_reg;

    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      pos_next;
    logic [CW-1:0]      pos_m1;
    logic [CW-1:0]      fill_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic [AW-1:0]      rd_addr;

    logic [START_W-1:0] cur_start_reg;
    logic [END_W-1:0]   cur_end_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_inc;
    logic [GAP_W-1:0]   gap_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_valid_reg;

    logic               wr_en;
    isched_entry_t      wr_data;
    logic               inside_cur;
    logic               ends_earlier;
    logic               gap_ok;

    // pointer and read address; the read follows the next pointer value
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            pos_next = fill_reg;
        end
        else if (cmd.shift)
        begin
            pos_next = pos_reg - 1'b1;
        end
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_first || cmd.scan_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
        pos_m1  = pos_next - 1'b1;
        rd_addr = cmd.scan_rd ? idx_next : pos_m1[AW-1:0];
    end

    assign wr_en   = cmd.place || cmd.shift;
    assign wr_data = cmd.shift ? rd_data_reg : isched_entry_t'{item_start_reg, item_end_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // greedy decision on the entry just read
    assign inside_cur   = (rd_data_reg.start_min >= cur_start_reg) &&
                          (END_W'(rd_data_reg.start_min) < cur_end_reg);
    assign ends_earlier = rd_data_reg.end_min < cur_end_reg;
    assign gap_ok       = SUM_W'(rd_data_reg.start_min) >=
                          (SUM_W'(cur_end_reg) + SUM_W'(gap_reg));
    assign count_inc    = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_start_reg <= in_start;
            item_end_reg   <= END_W'(in_start) + END_W'(in_duration);
            item_last_reg  <= in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            cur_start_reg <= '0;
            cur_end_reg   <= '0;
            count_reg     <= '0;
            gap_reg       <= GAP_RESET;
            out_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
            if (cfg_wr_en)
            begin
                gap_reg <= cfg_wr_data;
            end
            if (cmd.place)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (cmd.load_result)
            begin
                fill_reg <= '0;
            end
            if (cmd.scan_first)
            begin
                cur_start_reg <= rd_data_reg.start_min;
                cur_end_reg   <= rd_data_reg.end_min;
                count_reg     <= COUNT_W'(1);
            end
            else if (cmd.scan_step)
            begin
                if (inside_cur)
                begin
                    if (ends_earlier)
                    begin
                        cur_start_reg <= rd_data_reg.start_min;
                        cur_end_reg   <= rd_data_reg.end_min;
                    end
                end
                else if (gap_ok)
                begin
                    count_reg     <= count_inc;
                    cur_start_reg <= rd_data_reg.start_min;
                    cur_end_reg   <= rd_data_reg.end_min;
                end
            end
            if (cmd.load_result)
            begin
                out_count_reg <= count_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status           = '0;
        status.full      = (fill_reg == CW'(MAX_FILMS));
        status.pos_zero  = (pos_reg == '0);
        status.greater   = (rd_data_reg.start_min > item_start_reg);
        status.last_item = item_last_reg;
        status.scan_last = (CW'(idx_reg) == (fill_reg - 1'b1));
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

`ifndef SYNTHESIS
    // the store never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_FILMS))
        else $error("isched_dp: fill count beyond store depth");

    // each shift moves the insertion point down by one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |=> (pos_reg == $past(pos_reg) - 1'b1))
        else $error("isched_dp: insertion pointer did not step down");

    // a placement never lands in a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> !status.full && (pos_reg <= fill_reg))
        else $error("isched_dp: placement outside filled range");

    // a delivered count is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg && (out_count_reg != '0))
        else $error("isched_dp: empty count presented");
`endif

endmodule
